@@ rtl/triangle_barycentric_rasterizer_top_macros.svh @@
// Assertion macros for the triangle rasterizer checker.
// Used by rtl/tbr_checker.sv; expects clk and rst_n in scope.
`ifndef TRIANGLE_BARYCENTRIC_RASTERIZER_TOP_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication
`define TBR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbr checker: same-cycle rule violated");

// next-cycle implication
`define TBR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbr checker: next-cycle rule violated");

`endif

@@ rtl/tbr_pkg.sv @@
// Shared types, constants and helpers for the triangle rasterizer.
// No dependencies; imported by tbr_div and the top level.
`timescale 1ns / 1ps

package tbr_pkg;

    localparam int COORD_FRAC_BITS = 4;

    // divider widths: |cross| << 16 over |area|
    localparam int DIVIDEND_W = 52;
    localparam int DIVISOR_W  = 36;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_EDGE_TOL      = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic signed [17:0] WEIGHT_ONE = 18'sd65536;
    localparam logic signed [17:0] WEIGHT_NEG_ONE = -18'sd65536;

    // one pixel in coordinate units, and the smallest usable |area|
    localparam logic signed [17:0] ONE_PIX = 18'sd1 <<< COORD_FRAC_BITS;
    localparam logic signed [35:0] AREA_MIN = 36'sd1 <<< (2 * COORD_FRAC_BITS);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AREA0,
        ST_AREA1,
        ST_AREA2,
        ST_CROSS0,
        ST_CROSS1,
        ST_CROSS2,
        ST_CROSS3,
        ST_CROSS4,
        ST_DIV_U,
        ST_DIV_V,
        ST_WEIGHT,
        ST_DEPTH0,
        ST_DEPTH1,
        ST_DEPTH2,
        ST_DEPTH3,
        ST_EMIT
    } tbr_state_t;

    function automatic logic signed [17:0] min2(input logic signed [17:0] a,
                                                input logic signed [17:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [17:0] max2(input logic signed [17:0] a,
                                                input logic signed [17:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [17:0] sat_weight(input logic signed [54:0] v);
        logic signed [17:0] r;
        if (v > 55'sd131071)
            r = 18'sd131071;
        else if (v < -55'sd131072)
            r = -18'sd131072;
        else
            r = v[17:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_depth(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/tbr_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tbr_pkg for operand widths.
`timescale 1ns / 1ps

module tbr_div
    import tbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] dq_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // shift dividend out, quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVISOR_W])
            begin
                rem_reg <= diff[DIVISOR_W-1:0];
                dq_reg  <= {dq_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DIVISOR_W-1:0];
                dq_reg  <= {dq_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

@@ rtl/triangle_barycentric_rasterizer_top.sv @@
// Sequence: a load computes the area; a step forms the cross products, runs two
// divisions in tbr_div, weights, depth if covered; finished or degenerate steps emit.
// Throughput: one item at a time; in_stall stays high until the beat is in
// the output register, so the next beat can be taken from then on.
// Reset: rst_n async low; registers return to 800/800/4588, walk finished,
// triangle degenerate, no output beat pending.
`timescale 1ns / 1ps

module triangle_barycentric_rasterizer_top
    import tbr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // config write port
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [31:0] az,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by,
    input  logic signed [31:0] bz,
    input  logic signed [15:0] cx,
    input  logic signed [15:0] cy,
    input  logic signed [31:0] cz,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [14:0]        pixel_x,
    output logic [14:0]        pixel_y,
    output logic               covered,
    output logic signed [31:0] depth,
    output logic signed [17:0] weight_u,
    output logic signed [17:0] weight_v,
    output logic signed [17:0] weight_w,
    output logic               box_done
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [15:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd800;
            height_reg <= 12'd800;
            tol_reg    <= 16'd4588;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data[11:0];
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data[11:0];
                CFG_EDGE_TOL:      tol_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer state and handshake
    // ------------------------------------------------------------------
    tbr_state_t state_reg, state_next;
    logic       accept;
    logic       out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid || !out_stall;

    // ------------------------------------------------------------------
    // triangle and walk state
    // ------------------------------------------------------------------
    logic signed [15:0] x0_reg, y0_reg;
    logic signed [31:0] z0_reg, z1_reg, z2_reg;
    logic signed [16:0] abx_reg, acx_reg, aby_reg, acy_reg;
    logic signed [17:0] lo_y_reg, hi_x_reg, hi_y_reg;
    logic signed [17:0] walk_x_reg, walk_y_reg;
    logic signed [35:0] area_reg;
    logic               degen_reg;
    logic               finished_reg;

    // staged result of the item in flight
    logic               live_reg;      // step that visits a position
    logic               st_cov_reg;
    logic signed [31:0] st_depth_reg;
    logic signed [17:0] st_wu_reg, st_wv_reg, st_ww_reg;
    logic               st_done_reg;

    // working registers of the shared unit
    logic signed [49:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic signed [35:0] crx_reg, cry_reg;
    logic signed [52:0] qu_reg, qv_reg;

    // ------------------------------------------------------------------
    // load-time box: min/max over three vertices, clamp to screen
    // ------------------------------------------------------------------
    logic signed [17:0] ax18, ay18, bx18, by18, cx18, cy18;
    logic signed [17:0] lim_x, lim_y;
    logic signed [17:0] new_lo_x, new_lo_y, new_hi_x, new_hi_y;
    logic               new_fin;

    assign ax18 = {{2{ax[15]}}, ax};
    assign ay18 = {{2{ay[15]}}, ay};
    assign bx18 = {{2{bx[15]}}, bx};
    assign by18 = {{2{by[15]}}, by};
    assign cx18 = {{2{cx[15]}}, cx};
    assign cy18 = {{2{cy[15]}}, cy};

    assign lim_x = ($signed({6'd0, width_reg}) - 18'sd1) <<< COORD_FRAC_BITS;
    assign lim_y = ($signed({6'd0, height_reg}) - 18'sd1) <<< COORD_FRAC_BITS;

    assign new_lo_x = max2(18'sd0, min2(lim_x, min2(ax18, min2(bx18, cx18))));
    assign new_hi_x = min2(lim_x, max2(18'sd0, max2(ax18, max2(bx18, cx18))));
    assign new_lo_y = max2(18'sd0, min2(lim_y, min2(ay18, min2(by18, cy18))));
    assign new_hi_y = min2(lim_y, max2(18'sd0, max2(ay18, max2(by18, cy18))));
    assign new_fin  = (new_lo_x > new_hi_x) || (new_lo_y > new_hi_y);

    // ------------------------------------------------------------------
    // per-position terms
    // ------------------------------------------------------------------
    logic signed [17:0] pax18, pay18;
    logic signed [16:0] pax, pay;

    assign pax18 = {{2{x0_reg[15]}}, x0_reg} - walk_x_reg;
    assign pay18 = {{2{y0_reg[15]}}, y0_reg} - walk_y_reg;
    assign pax   = pax18[16:0];
    assign pay   = pay18[16:0];

    // ------------------------------------------------------------------
    // shared multiplier, product registered every cycle
    // ------------------------------------------------------------------
    logic signed [17:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [51:0] prod_ext;

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{2{prod_reg[49]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    // ------------------------------------------------------------------
    // shared divider
    // ------------------------------------------------------------------
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_num;
    logic [DIVISOR_W-1:0]  div_den;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quot;
    logic [35:0]           crx_mag, cry_mag;

    assign crx_mag = crx_reg[35] ? 36'(-crx_reg) : crx_reg;
    assign cry_mag = cry_reg[35] ? 36'(-cry_reg) : cry_reg;
    assign div_den = area_reg[35] ? 36'(-area_reg) : area_reg;

    tbr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    logic               neg_q;
    logic signed [52:0] q_signed;

    // sign of the quotient: sign of the numerator under test xor sign of the area
    assign neg_q    = ((state_reg == ST_DIV_U) ? crx_reg[35] : cry_reg[35]) ^ area_reg[35];
    assign q_signed = neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

    // ------------------------------------------------------------------
    // weights and coverage
    // ------------------------------------------------------------------
    logic signed [54:0] qw;
    logic signed [17:0] wu, wv, ww;
    logic signed [18:0] ntol;
    logic               cov;

    assign qw   = 55'sd65536 - {{2{qu_reg[52]}}, qu_reg} - {{2{qv_reg[52]}}, qv_reg};
    assign wu   = sat_weight({{2{qu_reg[52]}}, qu_reg});
    assign wv   = sat_weight({{2{qv_reg[52]}}, qv_reg});
    assign ww   = sat_weight(qw);
    assign ntol = -$signed({3'd0, tol_reg});
    assign cov  = !(($signed({wu[17], wu}) < ntol) || ($signed({wv[17], wv}) < ntol)
                    || ($signed({ww[17], ww}) < ntol));

    logic signed [51:0] depth_sum;
    assign depth_sum = acc_reg + prod_ext;

    // signed area of the triangle as it leaves the shared multiplier
    logic signed [35:0] area_new;
    assign area_new = acc_reg[35:0] - prod_reg[35:0];

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_LOAD)
                        state_next = ST_AREA0;
                    else if (finished_reg || degen_reg)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_CROSS0;
                end
            end
            ST_AREA0:  state_next = ST_AREA1;
            ST_AREA1:  state_next = ST_AREA2;
            ST_AREA2:  state_next = ST_EMIT;
            ST_CROSS0: state_next = ST_CROSS1;
            ST_CROSS1: state_next = ST_CROSS2;
            ST_CROSS2: state_next = ST_CROSS3;
            ST_CROSS3: state_next = ST_CROSS4;
            ST_CROSS4: state_next = ST_DIV_U;
            ST_DIV_U:  if (div_done) state_next = ST_DIV_V;
            ST_DIV_V:  if (div_done) state_next = ST_WEIGHT;
            ST_WEIGHT: state_next = cov ? ST_DEPTH0 : ST_EMIT;
            ST_DEPTH0: state_next = ST_DEPTH1;
            ST_DEPTH1: state_next = ST_DEPTH2;
            ST_DEPTH2: state_next = ST_DEPTH3;
            ST_DEPTH3: state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // per-state operand selection for the shared units
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = {crx_mag, 16'd0};
        unique case (state_reg)
            ST_AREA0:
            begin
                mul_a = {abx_reg[16], abx_reg};
                mul_b = {{15{acy_reg[16]}}, acy_reg};
            end
            ST_AREA1:
            begin
                mul_a = {acx_reg[16], acx_reg};
                mul_b = {{15{aby_reg[16]}}, aby_reg};
            end
            ST_CROSS0:
            begin
                mul_a = {acx_reg[16], acx_reg};
                mul_b = {{15{pay[16]}}, pay};
            end
            ST_CROSS1:
            begin
                mul_a = {pax[16], pax};
                mul_b = {{15{acy_reg[16]}}, acy_reg};
            end
            ST_CROSS2:
            begin
                mul_a = {pax[16], pax};
                mul_b = {{15{aby_reg[16]}}, aby_reg};
            end
            ST_CROSS3:
            begin
                mul_a = {abx_reg[16], abx_reg};
                mul_b = {{15{pay[16]}}, pay};
            end
            ST_CROSS4:
            begin
                div_start = 1'b1;
            end
            ST_DIV_U:
            begin
                div_start = div_done;
                div_num   = {cry_mag, 16'd0};
            end
            ST_DEPTH0:
            begin
                mul_a = st_ww_reg;
                mul_b = z0_reg;
            end
            ST_DEPTH1:
            begin
                mul_a = st_wu_reg;
                mul_b = z1_reg;
            end
            ST_DEPTH2:
            begin
                mul_a = st_wv_reg;
                mul_b = z2_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degen_reg    <= 1'b1;
            finished_reg <= 1'b1;
            out_valid    <= 1'b0;
        end
        else
        begin
            // load a new beat, or drop the one the receiver just took
            if (state_reg == ST_EMIT && out_free)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;

            if (accept && operation == OP_LOAD)
                finished_reg <= new_fin;
            else if (state_reg == ST_EMIT && out_free && live_reg
                     && walk_y_reg + ONE_PIX > hi_y_reg
                     && walk_x_reg + ONE_PIX > hi_x_reg)
                finished_reg <= 1'b1;

            if (state_reg == ST_AREA2)
                degen_reg <= (area_new < AREA_MIN) && (area_new > -AREA_MIN);
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            live_reg     <= (operation == OP_STEP) && !finished_reg;
            st_cov_reg   <= 1'b0;
            st_depth_reg <= '0;
            st_wu_reg    <= '0;
            st_wv_reg    <= '0;
            st_ww_reg    <= '0;
            st_done_reg  <= 1'b1;
            if (operation == OP_LOAD)
            begin
                x0_reg      <= ax;
                y0_reg      <= ay;
                z0_reg      <= az;
                z1_reg      <= bz;
                z2_reg      <= cz;
                abx_reg     <= {bx[15], bx} - {ax[15], ax};
                acx_reg     <= {cx[15], cx} - {ax[15], ax};
                aby_reg     <= {by[15], by} - {ay[15], ay};
                acy_reg     <= {cy[15], cy} - {ay[15], ay};
                lo_y_reg    <= new_lo_y;
                hi_x_reg    <= new_hi_x;
                hi_y_reg    <= new_hi_y;
                walk_x_reg  <= new_lo_x;
                walk_y_reg  <= new_lo_y;
                st_done_reg <= new_fin;
            end
            else if (!finished_reg && degen_reg)
            begin
                // degenerate triangle: fixed weights, never covered
                st_wu_reg <= WEIGHT_NEG_ONE;
                st_wv_reg <= WEIGHT_ONE;
                st_ww_reg <= WEIGHT_ONE;
            end
        end

        unique case (state_reg)
            ST_AREA1, ST_CROSS1, ST_CROSS3, ST_DEPTH1: acc_reg <= prod_ext;
            ST_AREA2:  area_reg <= area_new;
            ST_CROSS2: crx_reg  <= acc_reg[35:0] - prod_reg[35:0];
            ST_CROSS4: cry_reg  <= acc_reg[35:0] - prod_reg[35:0];
            ST_DIV_U:  if (div_done) qu_reg <= q_signed;
            ST_DIV_V:  if (div_done) qv_reg <= q_signed;
            ST_WEIGHT:
            begin
                st_wu_reg  <= wu;
                st_wv_reg  <= wv;
                st_ww_reg  <= ww;
                st_cov_reg <= cov;
            end
            ST_DEPTH2: acc_reg <= depth_sum;
            ST_DEPTH3: st_depth_reg <= sat_depth(depth_sum[51:16]);
            default: ;
        endcase

        // hand the beat to the output register and advance the walk
        if (state_reg == ST_EMIT && out_free)
        begin
            covered  <= st_cov_reg;
            depth    <= st_depth_reg;
            weight_u <= st_wu_reg;
            weight_v <= st_wv_reg;
            weight_w <= st_ww_reg;
            if (live_reg)
            begin
                pixel_x  <= walk_x_reg[14:0];
                pixel_y  <= walk_y_reg[14:0];
                box_done <= (walk_x_reg + ONE_PIX > hi_x_reg)
                            && (walk_y_reg + ONE_PIX > hi_y_reg);
                if (walk_y_reg + ONE_PIX <= hi_y_reg)
                    walk_y_reg <= walk_y_reg + ONE_PIX;
                else
                begin
                    walk_y_reg <= lo_y_reg;
                    if (walk_x_reg + ONE_PIX <= hi_x_reg)
                        walk_x_reg <= walk_x_reg + ONE_PIX;
                end
            end
            else
            begin
                pixel_x  <= '0;
                pixel_y  <= '0;
                box_done <= st_done_reg;
            end
        end
    end

endmodule

@@ rtl/tbr_checker.sv @@
// Port-level checker for the triangle rasterizer, bound to the top level.
// Depends on triangle_barycentric_rasterizer_top_macros.svh.
`timescale 1ns / 1ps
`include "triangle_barycentric_rasterizer_top_macros.svh"

module tbr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [14:0]        pixel_x,
    input logic [14:0]        pixel_y,
    input logic               covered,
    input logic signed [31:0] depth
);

    // one item at a time: an accepted beat closes the input
    `TBR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // uncovered beats carry no depth
    `TBR_ASSERT_NOW(a_no_depth_uncovered, out_valid && !covered, depth == 32'sd0)

    // a held beat stays offered
    `TBR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // a held beat keeps its payload
    `TBR_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                     $stable(pixel_x) && $stable(pixel_y) && $stable(depth))

endmodule

bind triangle_barycentric_rasterizer_top tbr_checker u_tbr_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking bench for triangle_barycentric_rasterizer_top: random and directed
// load/step beats, with a bit-exact predictor in a scoreboard class.
// Depends on tbr_pkg and the rasterizer RTL only.
`timescale 1ns / 1ps

module testbench;
    import tbr_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int PIX = 1 << COORD_FRAC_BITS;

    typedef struct {
        logic        op;
        logic [15:0] vx [3];
        logic [15:0] vy [3];
        logic [31:0] vz [3];
    } tri_beat_t;

    typedef struct {
        logic [14:0]        px;
        logic [14:0]        py;
        logic               cov;
        logic signed [31:0] dep;
        logic signed [17:0] wu;
        logic signed [17:0] wv;
        logic signed [17:0] ww;
        logic               done;
    } pixel_beat_t;

    // Scoreboard: tracks rasterizer state, predicts each beat, compares results.
    class raster_scoreboard;
        logic [11:0] scr_w, scr_h;
        logic [15:0] tol;
        longint      px_v [3], py_v [3], pz_v [3];
        longint      lo_x, lo_y, hi_x, hi_y, cur_x, cur_y, tri_area;
        bit          degen, walk_done;
        pixel_beat_t pending [$];
        int          errors;

        function void reset_state();
            scr_w = 800; scr_h = 800; tol = 4588;
            foreach (px_v[i]) begin px_v[i] = 0; py_v[i] = 0; pz_v[i] = 0; end
            lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0; cur_x = 0; cur_y = 0;
            tri_area = 0; degen = 1; walk_done = 1; errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == CFG_SCREEN_WIDTH) scr_w = val[11:0];
            else if (idx == CFG_SCREEN_HEIGHT) scr_h = val[11:0];
            else if (idx == CFG_EDGE_TOL) tol = val;
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint weight_quot(longint num, longint den);
            longint unsigned q;
            q = ((num < 0 ? -num : num) << 16) / (den < 0 ? -den : den);
            return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
        endfunction

        // Predict the result of one accepted beat and queue it.
        function void note_input(tri_beat_t b);
            pixel_beat_t r;
            longint lim_x, lim_y, mnx, mxx, mny, mxy, abx, aby, acx, acy, pax, pay;
            longint qu, qv, qw, wu, wv, ww, ntol, acc;
            r = '{default: '0};
            if (b.op == OP_LOAD) begin
                foreach (px_v[i]) begin
                    px_v[i] = longint'(signed'(b.vx[i]));
                    py_v[i] = longint'(signed'(b.vy[i]));
                    pz_v[i] = longint'(signed'(b.vz[i]));
                end
                lim_x = (longint'(scr_w) - 1) * PIX;
                lim_y = (longint'(scr_h) - 1) * PIX;
                mnx = px_v[0]; mxx = px_v[0]; mny = py_v[0]; mxy = py_v[0];
                for (int i = 1; i < 3; i++) begin
                    if (px_v[i] < mnx) mnx = px_v[i];
                    if (px_v[i] > mxx) mxx = px_v[i];
                    if (py_v[i] < mny) mny = py_v[i];
                    if (py_v[i] > mxy) mxy = py_v[i];
                end
                lo_x = (mnx < lim_x ? mnx : lim_x); lo_x = lo_x > 0 ? lo_x : 0;
                lo_y = (mny < lim_y ? mny : lim_y); lo_y = lo_y > 0 ? lo_y : 0;
                hi_x = (mxx > 0 ? mxx : 0); hi_x = hi_x < lim_x ? hi_x : lim_x;
                hi_y = (mxy > 0 ? mxy : 0); hi_y = hi_y < lim_y ? hi_y : lim_y;
                abx = px_v[1] - px_v[0]; acx = px_v[2] - px_v[0];
                aby = py_v[1] - py_v[0]; acy = py_v[2] - py_v[0];
                tri_area = abx * acy - acx * aby;
                degen = (tri_area < 0 ? -tri_area : tri_area) < (64'sd1 << (2 * COORD_FRAC_BITS));
                cur_x = lo_x; cur_y = lo_y;
                walk_done = (lo_x > hi_x) || (lo_y > hi_y);
                r.done = walk_done;
            end else if (walk_done) begin
                r.done = 1;
            end else begin
                if (degen) begin
                    wu = -65536; wv = 65536; ww = 65536;
                end else begin
                    abx = px_v[1] - px_v[0]; acx = px_v[2] - px_v[0]; pax = px_v[0] - cur_x;
                    aby = py_v[1] - py_v[0]; acy = py_v[2] - py_v[0]; pay = py_v[0] - cur_y;
                    qu = weight_quot(acx * pay - pax * acy, tri_area);
                    qv = weight_quot(pax * aby - abx * pay, tri_area);
                    qw = 65536 - qu - qv;
                    wu = sat(qu, -131072, 131071);
                    wv = sat(qv, -131072, 131071);
                    ww = sat(qw, -131072, 131071);
                    ntol = -longint'(tol);
                    r.cov = !(wu < ntol || wv < ntol || ww < ntol);
                    if (r.cov) begin
                        acc = ww * pz_v[0] + wu * pz_v[1] + wv * pz_v[2];
                        r.dep = 32'(sat(acc >>> 16, -64'sd2147483648, 64'sd2147483647));
                    end
                end
                r.px = cur_x[14:0]; r.py = cur_y[14:0];
                r.wu = wu[17:0]; r.wv = wv[17:0]; r.ww = ww[17:0];
                r.done = (cur_x + PIX > hi_x) && (cur_y + PIX > hi_y);
                // advance y inner, x outer
                if (cur_y + PIX <= hi_y) cur_y += PIX;
                else begin
                    cur_y = lo_y;
                    if (cur_x + PIX <= hi_x) cur_x += PIX;
                    else walk_done = 1;
                end
            end
            pending = {pending, r};
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(pixel_beat_t got);
            pixel_beat_t e;
            if (pending.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.px !== e.px) report($sformatf("pixel_x %0d want %0d", got.px, e.px));
            if (got.py !== e.py) report($sformatf("pixel_y %0d want %0d", got.py, e.py));
            if (got.cov !== e.cov) report($sformatf("covered %0d want %0d", got.cov, e.cov));
            if (got.dep !== e.dep) report($sformatf("depth %0d want %0d", got.dep, e.dep));
            if (got.wu !== e.wu) report($sformatf("weight_u %0d want %0d", got.wu, e.wu));
            if (got.wv !== e.wv) report($sformatf("weight_v %0d want %0d", got.wv, e.wv));
            if (got.ww !== e.ww) report($sformatf("weight_w %0d want %0d", got.ww, e.ww));
            if (got.done !== e.done) report($sformatf("box_done %0d want %0d", got.done, e.done));
        endtask
    endclass

    logic               clk, rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid, in_stall, operation;
    logic signed [15:0] ax, ay, bx, by, cx, cy;
    logic signed [31:0] az, bz, cz;
    logic               out_valid, out_stall;
    logic [14:0]        pixel_x, pixel_y;
    logic               covered, box_done;
    logic signed [31:0] depth;
    logic signed [17:0] weight_u, weight_v, weight_w;

    raster_scoreboard sb;
    bit quiet;          // no idling on either side in the closing part
    bit long_hold_req;  // ask the receiver for one long hold-off

    triangle_barycentric_rasterizer_top dut (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Safety net: end the run if beats stop flowing.
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Check every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{pixel_x, pixel_y, covered, depth,
                              weight_u, weight_v, weight_w, box_done});
    end

    // Receiver: alternate ready stretches with stall bursts; one long hold-off on request.
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                out_stall <= 1'b1;
                hold = 0;
                while (hold < 700)
                begin
                    @(posedge clk);
                    hold++;
                end
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Present one beat and hold it until accepted, then maybe idle a burst.
    task automatic send_beat(input tri_beat_t b);
        in_valid  <= 1'b1;
        operation <= b.op;
        ax <= b.vx[0]; ay <= b.vy[0]; az <= b.vz[0];
        bx <= b.vx[1]; by <= b.vy[1]; bz <= b.vz[1];
        cx <= b.vx[2]; cy <= b.vy[2]; cz <= b.vz[2];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(b);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic load_tri(input int x0, y0, x1, y1, x2, y2,
                            input logic [31:0] z0, z1, z2);
        tri_beat_t b;
        b.op = OP_LOAD;
        b.vx = '{x0[15:0], x1[15:0], x2[15:0]};
        b.vy = '{y0[15:0], y1[15:0], y2[15:0]};
        b.vz = '{z0, z1, z2};
        send_beat(b);
    endtask

    // Steps carry random junk in the vertex fields; the block ignores it.
    task automatic step_box(input int count);
        tri_beat_t b;
        repeat (count)
        begin
            b.op = OP_STEP;
            foreach (b.vx[i])
            begin
                b.vx[i] = 16'($urandom);
                b.vy[i] = 16'($urandom);
                b.vz[i] = $urandom;
            end
            send_beat(b);
        end
    endtask

    // Write a register only with the block drained.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_write <= 1'b0;
    endtask

    // Small triangle near a random spot so walks stay short; fraction bits random.
    task automatic random_small_tri();
        int bx0, by0;
        bx0 = $urandom_range(0, 700 * PIX);
        by0 = $urandom_range(0, 700 * PIX);
        load_tri(bx0, by0,
                 bx0 + $urandom_range(0, 64) - 16, by0 + $urandom_range(0, 64) - 16,
                 bx0 + $urandom_range(0, 64) - 16, by0 + $urandom_range(0, 64) - 16,
                 $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        logic [15:0] phase_w [6];
        logic [15:0] phase_h [6];
        logic [15:0] phase_t [6];
        int sent;
        int n;
        phase_w = '{800, 1, 2048, 640, 16, 1024};
        phase_h = '{800, 1, 2048, 480, 16, 768};
        phase_t = '{4588, 0, 65535, 1000, 65535, 4588};
        sb = new();
        sb.reset_state();
        quiet = 0;
        long_hold_req = 0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0; cfg_index <= CFG_SCREEN_WIDTH; cfg_data <= '0;
        in_valid <= 1'b0; operation <= OP_LOAD;
        ax <= '0; ay <= '0; az <= '0; bx <= '0; by <= '0; bz <= '0;
        cx <= '0; cy <= '0; cz <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: step before any load, a small right triangle walked past its end,
        // a degenerate one, full-range extremes, and an off-screen one clamped to a one-pixel box.
        step_box(1);
        load_tri(32, 32, 64, 32, 32, 64, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        step_box(10);
        load_tri(16, 16, 48, 48, 80, 80, 32'h0, 32'h0, 32'h0);
        step_box(2);
        load_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        step_box(2);
        load_tri(-100, -100, -50, -100, -100, -50, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
        step_box(1);
        write_reg(CFG_UNUSED, 16'hFFFF);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_SCREEN_WIDTH, phase_w[ph]);
            write_reg(CFG_SCREEN_HEIGHT, phase_h[ph]);
            write_reg(CFG_EDGE_TOL, phase_t[ph]);
            quiet = (ph == 5);
            if (ph == 1) long_hold_req = 1;
            sent = 0;
            while (sent < 100)
            begin
                case ($urandom_range(0, 9))
                    0: begin // noise: full-range load
                        load_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                        sent++;
                    end
                    1: begin // noise: stray steps
                        n = $urandom_range(1, 3);
                        step_box(n);
                        sent += n;
                    end
                    default: begin
                        n = $urandom_range(1, 30);
                        random_small_tri();
                        step_box(n);
                        sent += n + 1;
                    end
                endcase
            end
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
